/* hw/rtl/lcdns_pkg.sv */
// Shared types, constants and helpers for the character LCD nibble sequencer.
`timescale 1ns / 1ps

package lcdns_pkg;

    // Command codes carried on the request stream
    localparam logic [2:0] CMD_TICK       = 3'd0;
    localparam logic [2:0] CMD_COMMAND    = 3'd1;
    localparam logic [2:0] CMD_WRITE_CHAR = 3'd2;
    localparam logic [2:0] CMD_LOCATE     = 3'd3;
    localparam logic [2:0] CMD_INIT       = 3'd4;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_ENABLE_TICKS  = 3'd0;
    localparam logic [2:0] REG_SETTLE_TICKS  = 3'd1;
    localparam logic [2:0] REG_CLEAR_EXTRA   = 3'd2;
    localparam logic [2:0] REG_INIT_GAP      = 3'd3;
    localparam logic [2:0] REG_INIT_FINAL    = 3'd4;

    // Register reset values
    localparam logic [7:0] RST_ENABLE_TICKS = 8'd2;
    localparam logic [7:0] RST_SETTLE_TICKS = 8'd2;
    localparam logic [7:0] RST_CLEAR_EXTRA  = 8'd2;
    localparam logic [7:0] RST_INIT_GAP     = 8'd4;
    localparam logic [9:0] RST_INIT_FINAL   = 10'd200;

    // LCD instruction bytes: clear and home with special timing, and the DDRAM row addresses
    localparam logic [7:0] LCD_CLEAR       = 8'h01;
    localparam logic [7:0] LCD_RETURN_HOME = 8'h02;
    localparam logic [7:0] LCD_DDRAM_ROW1  = 8'h80;
    localparam logic [7:0] LCD_DDRAM_ROW2  = 8'hC0;

    // Init sequence step codes: 0 means not in init, 1..6 the current byte
    localparam logic [2:0] INIT_NONE = 3'd0;
    localparam logic [2:0] INIT_LAST = 3'd6;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HI_EN,
        PH_LO_SETUP,
        PH_LO_EN,
        PH_SETTLE,
        PH_FINAL
    } t_phase;

    typedef struct packed {
        logic [7:0] enable_ticks;
        logic [7:0] settle_ticks;
        logic [7:0] clear_extra_ticks;
        logic [7:0] init_gap_ticks;
        logic [9:0] init_final_ticks;
    } t_cfg;

    typedef struct packed {
        logic       reg_select;
        logic       enable_pin;
        logic [3:0] data_nibble;
        logic       busy_res;
        logic       rejected;
    } t_result;

    // Power-up byte sequence, indexed from zero
    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h33;
            3'd1:    b = 8'h32;
            3'd2:    b = 8'h28;
            3'd3:    b = 8'h0C;
            3'd4:    b = 8'h06;
            3'd5:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* hw/rtl/lcdns_cfg.sv */
// APB-style register bank holding the timing configuration.
`timescale 1ns / 1ps

module lcdns_cfg
    import lcdns_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable_ticks      <= RST_ENABLE_TICKS;
            r_cfg.settle_ticks      <= RST_SETTLE_TICKS;
            r_cfg.clear_extra_ticks <= RST_CLEAR_EXTRA;
            r_cfg.init_gap_ticks    <= RST_INIT_GAP;
            r_cfg.init_final_ticks  <= RST_INIT_FINAL;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ENABLE_TICKS: r_cfg.enable_ticks      <= pwdata[7:0];
                REG_SETTLE_TICKS: r_cfg.settle_ticks      <= pwdata[7:0];
                REG_CLEAR_EXTRA:  r_cfg.clear_extra_ticks <= pwdata[7:0];
                REG_INIT_GAP:     r_cfg.init_gap_ticks    <= pwdata[7:0];
                REG_INIT_FINAL:   r_cfg.init_final_ticks  <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // Read-back mux
    always_comb begin
        unique case (reg_idx)
            REG_ENABLE_TICKS: prdata = {24'd0, r_cfg.enable_ticks};
            REG_SETTLE_TICKS: prdata = {24'd0, r_cfg.settle_ticks};
            REG_CLEAR_EXTRA:  prdata = {24'd0, r_cfg.clear_extra_ticks};
            REG_INIT_GAP:     prdata = {24'd0, r_cfg.init_gap_ticks};
            REG_INIT_FINAL:   prdata = {22'd0, r_cfg.init_final_ticks};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

/* hw/rtl/lcdns_core.sv */
// Sequencer state and single-step update for one request or tick.
`timescale 1ns / 1ps

module lcdns_core
    import lcdns_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [2:0] i_command,
    input  logic [7:0] i_byte_value,
    input  logic [1:0] i_row,
    input  logic [7:0] i_column,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    t_phase     r_phase,      n_phase;
    logic [2:0] r_init_step,  n_init_step;
    logic [7:0] r_latched,    n_latched;
    logic [9:0] r_wait,       n_wait;
    logic       r_rs,         n_rs;
    logic       r_enable,     n_enable;
    logic [3:0] r_nibble,     n_nibble;

    logic       is_request;
    logic       rejected;
    logic       start;
    logic [7:0] start_byte;
    logic       start_rs;
    logic       after_settle;
    logic [9:0] wait_dec;
    logic       wait_done;
    logic [9:0] en_len;
    logic [9:0] settle_len;
    logic [7:0] col_m1;

    assign is_request = (i_command == CMD_COMMAND) || (i_command == CMD_WRITE_CHAR) ||
                        (i_command == CMD_LOCATE)  || (i_command == CMD_INIT);
    assign wait_dec   = (r_wait != 10'd0) ? (r_wait - 10'd1) : 10'd0;
    assign wait_done  = (wait_dec == 10'd0);
    assign en_len     = (i_cfg.enable_ticks == 8'd0) ? 10'd1
                                                     : {2'd0, i_cfg.enable_ticks};
    assign col_m1     = i_column - 8'd1;

    // Settle length: base wait plus clear/home and early-init extras
    always_comb begin
        settle_len = {2'd0, i_cfg.settle_ticks};
        if (!r_rs && (r_latched == LCD_CLEAR || r_latched == LCD_RETURN_HOME))
            settle_len = settle_len + {2'd0, i_cfg.clear_extra_ticks};
        if (r_init_step == 3'd1 || r_init_step == 3'd2)
            settle_len = settle_len + {2'd0, i_cfg.init_gap_ticks};
    end

    // Next state
    always_comb begin
        n_phase      = r_phase;
        n_init_step  = r_init_step;
        n_latched    = r_latched;
        n_wait       = r_wait;
        n_rs         = r_rs;
        n_enable     = r_enable;
        n_nibble     = r_nibble;
        rejected     = 1'b0;
        start        = 1'b0;
        start_byte   = 8'd0;
        start_rs     = 1'b0;
        after_settle = 1'b0;

        if (is_request) begin
            if (r_phase != PH_IDLE) begin
                rejected = 1'b1;
            end else begin
                case (i_command)
                    CMD_COMMAND: begin
                        start      = 1'b1;
                        start_byte = i_byte_value;
                    end
                    CMD_WRITE_CHAR: begin
                        start      = 1'b1;
                        start_byte = i_byte_value;
                        start_rs   = 1'b1;
                    end
                    CMD_LOCATE: begin
                        if (i_row == 2'd1) begin
                            start      = 1'b1;
                            start_byte = col_m1 | LCD_DDRAM_ROW1;
                        end else if (i_row == 2'd2) begin
                            start      = 1'b1;
                            start_byte = col_m1 | LCD_DDRAM_ROW2;
                        end
                    end
                    default: begin
                        n_init_step = 3'd1;
                        start       = 1'b1;
                        start_byte  = init_byte(3'd0);
                    end
                endcase
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: ;
                PH_HI_EN: begin
                    n_wait = wait_dec;
                    if (wait_done) begin
                        n_enable = 1'b0;
                        n_nibble = r_latched[3:0];
                        n_phase  = PH_LO_SETUP;
                    end
                end
                PH_LO_SETUP: begin
                    n_enable = 1'b1;
                    n_wait   = en_len;
                    n_phase  = PH_LO_EN;
                end
                PH_LO_EN: begin
                    n_wait = wait_dec;
                    if (wait_done) begin
                        n_enable = 1'b0;
                        if (settle_len == 10'd0) begin
                            after_settle = 1'b1;
                        end else begin
                            n_wait  = settle_len;
                            n_phase = PH_SETTLE;
                        end
                    end
                end
                PH_SETTLE: begin
                    n_wait = wait_dec;
                    if (wait_done)
                        after_settle = 1'b1;
                end
                PH_FINAL: begin
                    n_wait = wait_dec;
                    if (wait_done)
                        n_phase = PH_IDLE;
                end
                default: begin
                    n_phase     = PH_IDLE;
                    n_init_step = INIT_NONE;
                end
            endcase
        end

        // End of a byte: next init byte, final wait, or back to idle
        if (after_settle) begin
            if (r_init_step != INIT_NONE && r_init_step < INIT_LAST) begin
                n_init_step = r_init_step + 3'd1;
                start       = 1'b1;
                start_byte  = init_byte(r_init_step);
                start_rs    = 1'b0;
            end else if (r_init_step == INIT_LAST) begin
                n_init_step = INIT_NONE;
                if (i_cfg.init_final_ticks == 10'd0) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_wait  = i_cfg.init_final_ticks;
                    n_phase = PH_FINAL;
                end
            end else begin
                n_init_step = INIT_NONE;
                n_phase     = PH_IDLE;
            end
        end

        // Launch a byte: high nibble on the pins with enable raised
        if (start) begin
            n_latched = start_byte;
            n_rs      = start_rs;
            n_nibble  = start_byte[7:4];
            n_enable  = 1'b1;
            n_wait    = en_len;
            n_phase   = PH_HI_EN;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_init_step <= INIT_NONE;
            r_latched   <= 8'd0;
            r_wait      <= 10'd0;
            r_rs        <= 1'b0;
            r_enable    <= 1'b0;
            r_nibble    <= 4'd0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_init_step <= n_init_step;
            r_latched   <= n_latched;
            r_wait      <= n_wait;
            r_rs        <= n_rs;
            r_enable    <= n_enable;
            r_nibble    <= n_nibble;
        end
    end

    // Result for this item, taken by the output register
    assign o_result.reg_select  = n_rs;
    assign o_result.enable_pin  = n_enable;
    assign o_result.data_nibble = n_nibble;
    assign o_result.busy_res    = (n_phase != PH_IDLE);
    assign o_result.rejected    = rejected;

endmodule

/* hw/rtl/char_lcd_nibble_sequencer.sv */
// Top level: request stream in, pin-state stream out, APB timing registers.
// The result of a request or tick is registered at its accepting edge.
// Throughput: one item per cycle; input is taken while the output register is empty or
// drained in the same cycle, so only a result held by a stalled receiver stalls the input.
// Reset (i_rst_n low, synchronous): sequencer idle, pins low, output empty,
// timing registers back to their defaults.
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer
    import lcdns_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [7:0] byte_value, [9:8] row, [17:10] column, zero pad
    input  logic [2:0]  s_axis_tuser,  // [2:0] command
    // pin-state stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [0] enable_pin, [4:1] data_nibble, [5] busy_res,
                                       // [6] rejected, [7] zero
    output logic        m_axis_tuser,  // [0] reg_select
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg    cfg;
    t_result result;
    t_result r_out;
    logic    r_out_valid;
    logic    accept;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    lcdns_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lcdns_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_command    (s_axis_tuser),
        .i_byte_value (s_axis_tdata[7:0]),
        .i_row        (s_axis_tdata[9:8]),
        .i_column     (s_axis_tdata[17:10]),
        .i_cfg        (cfg),
        .o_result     (result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.reg_select;
    assign m_axis_tdata  = {1'b0, r_out.rejected, r_out.busy_res,
                            r_out.data_nibble, r_out.enable_pin};

endmodule

/* dv/char_lcd_nibble_sequencer_tb.sv */
// Self-checking testbench for the character LCD nibble sequencer: pin-state prediction per request.
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_tb;
    import lcdns_pkg::*;

    // Command codes above CMD_INIT act as ticks
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    // Locate rows
    localparam logic [1:0] ROW_NONE   = 2'd0;
    localparam logic [1:0] ROW_TOP    = 2'd1;
    localparam logic [1:0] ROW_BOTTOM = 2'd2;
    localparam logic [1:0] ROW_SPARE  = 2'd3;

    // Power-up steps that get the extra gap
    localparam logic [2:0] INIT_FIRST  = 3'd1;
    localparam logic [2:0] INIT_SECOND = 3'd2;

    // Power-up bytes, entry 0 in the low byte
    localparam logic [5:0][7:0] POWER_UP_SEQ = {8'h01, 8'h06, 8'h0C, 8'h28, 8'h32, 8'h33};

    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 80;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // [7:0] byte_value, [9:8] row, [17:10] column, zero pad
    logic [2:0]  s_axis_tuser = '0;   // [2:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [0] enable_pin, [4:1] data_nibble, [5] busy_res,
                                      // [6] rejected, [7] zero
    logic        m_axis_tuser;        // [0] reg_select
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    char_lcd_nibble_sequencer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the sequencer and its timing registers
    t_cfg       timing = '{enable_ticks: RST_ENABLE_TICKS, settle_ticks: RST_SETTLE_TICKS,
                           clear_extra_ticks: RST_CLEAR_EXTRA, init_gap_ticks: RST_INIT_GAP,
                           init_final_ticks: RST_INIT_FINAL};
    t_phase     lcd_phase = PH_IDLE;
    logic [2:0] lcd_step = INIT_NONE;
    logic [7:0] lcd_byte = '0;
    logic [9:0] lcd_wait = '0;
    logic       lcd_rs = 1'b0;
    logic       lcd_en = 1'b0;
    logic [3:0] lcd_nib = '0;

    t_result pending_pins[$];
    int      mismatches = 0;
    int      moving_items = 0;
    bit      sender_gaps = 1'b1;
    bit      ready_stalls = 1'b1;
    int      stall_left = 0;

    // ---------------- predictor ----------------

    function automatic logic [9:0] enable_len();
        return (timing.enable_ticks == 8'd0) ? 10'd1 : {2'b00, timing.enable_ticks};
    endfunction

    function automatic void load_byte(input logic [7:0] b, input logic rs);
        lcd_byte  = b;
        lcd_rs    = rs;
        lcd_nib   = b[7:4];
        lcd_en    = 1'b1;
        lcd_wait  = enable_len();
        lcd_phase = PH_HI_EN;
    endfunction

    // Next power-up byte, final wait, or back to idle
    function automatic void end_of_byte();
        if (lcd_step != INIT_NONE && lcd_step < INIT_LAST) begin
            lcd_step = lcd_step + 3'd1;
            load_byte(POWER_UP_SEQ[lcd_step - 3'd1], 1'b0);
        end else if (lcd_step == INIT_LAST) begin
            lcd_step = INIT_NONE;
            if (timing.init_final_ticks == 10'd0) begin
                lcd_phase = PH_IDLE;
            end else begin
                lcd_wait  = timing.init_final_ticks;
                lcd_phase = PH_FINAL;
            end
        end else begin
            lcd_step  = INIT_NONE;
            lcd_phase = PH_IDLE;
        end
    endfunction

    // Settle wait; clear/home and the first two power-up bytes add their extras
    function automatic void start_settle();
        logic [9:0] w;
        w = {2'b00, timing.settle_ticks};
        if (!lcd_rs && (lcd_byte == LCD_CLEAR || lcd_byte == LCD_RETURN_HOME))
            w = w + {2'b00, timing.clear_extra_ticks};
        if (lcd_step == INIT_FIRST || lcd_step == INIT_SECOND)
            w = w + {2'b00, timing.init_gap_ticks};
        if (w == 10'd0) begin
            end_of_byte();
        end else begin
            lcd_wait  = w;
            lcd_phase = PH_SETTLE;
        end
    endfunction

    function automatic void tick_sequencer();
        case (lcd_phase)
            PH_IDLE: ;
            PH_HI_EN: begin
                if (lcd_wait != 10'd0) lcd_wait = lcd_wait - 10'd1;
                if (lcd_wait == 10'd0) begin
                    lcd_en    = 1'b0;
                    lcd_nib   = lcd_byte[3:0];
                    lcd_phase = PH_LO_SETUP;
                end
            end
            PH_LO_SETUP: begin
                lcd_en    = 1'b1;
                lcd_wait  = enable_len();
                lcd_phase = PH_LO_EN;
            end
            PH_LO_EN: begin
                if (lcd_wait != 10'd0) lcd_wait = lcd_wait - 10'd1;
                if (lcd_wait == 10'd0) begin
                    lcd_en = 1'b0;
                    start_settle();
                end
            end
            PH_SETTLE: begin
                if (lcd_wait != 10'd0) lcd_wait = lcd_wait - 10'd1;
                if (lcd_wait == 10'd0) end_of_byte();
            end
            PH_FINAL: begin
                if (lcd_wait != 10'd0) lcd_wait = lcd_wait - 10'd1;
                if (lcd_wait == 10'd0) lcd_phase = PH_IDLE;
            end
            default: begin
                lcd_phase = PH_IDLE;
                lcd_step  = INIT_NONE;
            end
        endcase
    endfunction

    // Pin state after one accepted request or tick
    function automatic t_result predict_pins(input logic [2:0] cmd, input logic [7:0] bval,
                                             input logic [1:0] row, input logic [7:0] col);
        t_result    res;
        logic [7:0] addr;
        res.rejected = 1'b0;
        addr = col - 8'd1;
        if (cmd >= CMD_COMMAND && cmd <= CMD_INIT) begin
            if (lcd_phase != PH_IDLE) begin
                res.rejected = 1'b1;
            end else begin
                case (cmd)
                    CMD_COMMAND:    load_byte(bval, 1'b0);
                    CMD_WRITE_CHAR: load_byte(bval, 1'b1);
                    CMD_LOCATE: begin
                        if (row == ROW_TOP)
                            load_byte(addr | LCD_DDRAM_ROW1, 1'b0);
                        else if (row == ROW_BOTTOM)
                            load_byte(addr | LCD_DDRAM_ROW2, 1'b0);
                    end
                    default: begin
                        lcd_step = INIT_FIRST;
                        load_byte(POWER_UP_SEQ[0], 1'b0);
                    end
                endcase
            end
        end else begin
            tick_sequencer();
        end
        res.reg_select  = lcd_rs;
        res.enable_pin  = lcd_en;
        res.data_nibble = lcd_nib;
        res.busy_res    = (lcd_phase != PH_IDLE);
        return res;
    endfunction

    // ---------------- stimulus ----------------

    // Send one request; valid stays high after acceptance for back-to-back traffic
    task automatic send_item(input logic [2:0] cmd, input logic [7:0] bval,
                             input logic [1:0] row, input logic [7:0] col);
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, col, row, bval};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        if ((cmd >= CMD_COMMAND && cmd <= CMD_INIT) || lcd_phase != PH_IDLE)
            moving_items++;
        pending_pins.push_back(predict_pins(cmd, bval, row, col));
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic send_request(input logic [2:0] cmd, input logic [7:0] bval);
        send_item(cmd, bval, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endtask

    // Tick until the sequence ends, mixing in spare codes and requests that must bounce
    task automatic run_to_idle(input int bounce_pct);
        int r;
        while (lcd_phase != PH_IDLE) begin
            r = $urandom_range(0, 99);
            if (r < bounce_pct)
                send_item(3'($urandom_range(CMD_COMMAND, CMD_INIT)),
                          8'($urandom_range(0, 255)),
                          2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            else if (r < bounce_pct + 5)
                send_item(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
                          8'($urandom_range(0, 255)),
                          2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            else
                send_tick();
        end
    endtask

    // Drop valid and hold off until every predicted result has come back
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_pins.size() != 0);
    endtask

    // Write all five timing registers; sequencer must be idle and drained
    task automatic program_timing(input t_cfg want_cfg);
        logic [2:0]  idx;
        logic [31:0] val;
        for (idx = REG_ENABLE_TICKS; idx <= REG_INIT_FINAL; idx++) begin
            case (idx)
                REG_ENABLE_TICKS: val = {24'd0, want_cfg.enable_ticks};
                REG_SETTLE_TICKS: val = {24'd0, want_cfg.settle_ticks};
                REG_CLEAR_EXTRA:  val = {24'd0, want_cfg.clear_extra_ticks};
                REG_INIT_GAP:     val = {24'd0, want_cfg.init_gap_ticks};
                default:          val = {22'd0, want_cfg.init_final_ticks};
            endcase
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= val;
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        timing = want_cfg;
    endtask

    task automatic retime(input logic [7:0] en, input logic [7:0] st, input logic [7:0] clr,
                          input logic [7:0] gap, input logic [9:0] fin);
        t_cfg c;
        c = '{enable_ticks: en, settle_ticks: st, clear_extra_ticks: clr,
              init_gap_ticks: gap, init_final_ticks: fin};
        wait_results();
        program_timing(c);
    endtask

    // ---------------- tests ----------------

    // Reset timing: idle tick, plain command/data bytes, clear and home waits
    task automatic test_reset_defaults();
        send_tick();
        send_request(CMD_COMMAND, LCD_CLEAR);
        run_to_idle(0);
        send_request(CMD_WRITE_CHAR, 8'hA5);
        run_to_idle(0);
        send_request(CMD_COMMAND, LCD_RETURN_HOME);
        run_to_idle(0);
        send_request(CMD_COMMAND, 8'hFF);
        run_to_idle(0);
        send_request(CMD_WRITE_CHAR, 8'h00);
        run_to_idle(0);
    endtask

    // Locate on both rows, column wrap, and rows that send nothing
    task automatic test_locate();
        send_item(CMD_LOCATE, 8'h00, ROW_TOP, 8'd1);
        run_to_idle(0);
        send_item(CMD_LOCATE, 8'hFF, ROW_BOTTOM, 8'd0);
        run_to_idle(0);
        send_item(CMD_LOCATE, 8'h5A, ROW_BOTTOM, 8'd255);
        run_to_idle(0);
        send_item(CMD_LOCATE, 8'hA5, ROW_TOP, 8'd128);
        run_to_idle(0);
        send_item(CMD_LOCATE, 8'hFF, ROW_NONE, 8'd5);
        send_item(CMD_LOCATE, 8'h00, ROW_SPARE, 8'd255);
        send_tick();
    endtask

    // Every request kind while busy is dropped; spare codes advance like ticks
    task automatic test_busy_and_spare();
        logic [2:0] cmd;
        send_request(CMD_WRITE_CHAR, 8'h3C);
        for (cmd = CMD_COMMAND; cmd <= CMD_INIT; cmd++)
            send_item(cmd, 8'h01, ROW_TOP, 8'd1);
        for (cmd = CMD_SPARE_LO; cmd != CMD_TICK; cmd++)
            send_item(cmd, 8'hFF, ROW_SPARE, 8'hFF);
        run_to_idle(0);
    endtask

    // Power-up sequence with short waits, one bounced request just after it starts
    task automatic test_power_up();
        retime(8'd1, 8'd1, 8'd1, 8'd2, 10'd3);
        send_request(CMD_INIT, 8'h00);
        send_request(CMD_INIT, 8'hFF);
        run_to_idle(0);
        send_request(CMD_COMMAND, LCD_CLEAR);
        run_to_idle(0);
    endtask

    // Zero timing, and waits that run past eight bits
    task automatic test_timing_extremes();
        retime(8'd0, 8'd0, 8'd0, 8'd0, 10'd0);
        send_request(CMD_INIT, 8'h00);
        run_to_idle(0);
        send_request(CMD_COMMAND, LCD_RETURN_HOME);
        run_to_idle(0);
        retime(8'd1, 8'd1, 8'd255, 8'd0, 10'd1);
        send_request(CMD_WRITE_CHAR, LCD_CLEAR);
        run_to_idle(0);
        send_request(CMD_COMMAND, LCD_CLEAR);
        run_to_idle(0);
        retime(8'd0, 8'd0, 8'd0, 8'd2, 10'd300);
        send_request(CMD_INIT, 8'h00);
        run_to_idle(2);
        send_request(CMD_COMMAND, LCD_RETURN_HOME);
        run_to_idle(0);
    endtask

    // Mostly complete requests with random payload, plus idle ticks and broken sequences
    task automatic test_random_traffic();
        int         ph;
        int         r;
        logic [2:0] cmd;
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == RANDOM_PHASES - 1) begin
                sender_gaps  = 1'b0;
                ready_stalls = 1'b0;
            end
            retime(8'($urandom_range(0, 4)), 8'($urandom_range(0, 5)),
                   8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
                   (ph == 1) ? 10'd0 : 10'($urandom_range(1, 40)));
            moving_items = 0;
            while (moving_items < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    cmd = ($urandom_range(0, 99) < 8) ? CMD_INIT
                                                      : 3'($urandom_range(CMD_COMMAND, CMD_LOCATE));
                    send_item(cmd, 8'($urandom_range(0, 255)),
                              ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                                          : 2'($urandom_range(1, 2)),
                              8'($urandom_range(0, 255)));
                    run_to_idle(8);
                end else if (r < 80) begin
                    repeat ($urandom_range(1, 3)) send_tick();
                end else if (r < 88) begin
                    send_item(CMD_LOCATE, 8'($urandom_range(0, 255)),
                              ($urandom_range(0, 1) == 0) ? ROW_NONE : ROW_SPARE,
                              8'($urandom_range(0, 255)));
                end else begin
                    // request, a few ticks, a second request that may bounce
                    send_request(3'($urandom_range(CMD_COMMAND, CMD_WRITE_CHAR)),
                                 8'($urandom_range(0, 255)));
                    repeat ($urandom_range(0, 3)) send_tick();
                    send_request(3'($urandom_range(CMD_COMMAND, CMD_INIT)),
                                 8'($urandom_range(0, 255)));
                    run_to_idle(0);
                end
                if ($urandom_range(0, 19) == 0)
                    wait_results();
            end
            run_to_idle(0);
        end
    endtask

    // ---------------- result checking ----------------

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : pin_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pins.size() == 0) begin
                $error("pin state returned with no request outstanding");
                mismatches++;
            end else begin
                want = pending_pins.pop_front();
                check_field("reg_select", want.reg_select, m_axis_tuser);
                check_field("enable_pin", want.enable_pin, m_axis_tdata[0]);
                check_field("data_nibble", want.data_nibble, m_axis_tdata[4:1]);
                check_field("busy_res", want.busy_res, m_axis_tdata[5]);
                check_field("rejected", want.rejected, m_axis_tdata[6]);
            end
        end
    end

    // Receiver backpressure in random bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (ready_stalls && $urandom_range(0, 7) == 0) begin
            stall_left    <= $urandom_range(0, 5);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        int drain;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_locate();
        test_busy_and_spare();
        test_power_up();
        test_timing_extremes();
        test_random_traffic();
        s_axis_tvalid <= 1'b0;
        for (drain = 0; drain < 1000 && pending_pins.size() != 0; drain++)
            @(posedge i_clk);
        if (pending_pins.size() != 0) begin
            $error("%0d pin states never returned", pending_pins.size());
            mismatches++;
        end
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
